>>> rtl/ipv4_receive_header_filter_macros.svh
// Assertion macros shared by the receive header filter RTL.
// Define ASSERT_OFF to compile the assertions out.
`ifndef IPV4_RECEIVE_HEADER_FILTER_MACROS_SVH
`define IPV4_RECEIVE_HEADER_FILTER_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/ipv4rhf_pkg.sv
package ipv4rhf_pkg;

  typedef enum logic [2:0] {
    VERDICT_ACCEPTED      = 3'd0,
    VERDICT_SHORT         = 3'd1,
    VERDICT_VERSION       = 3'd2,
    VERDICT_HEADER_LENGTH = 3'd3,
    VERDICT_TOTAL_LENGTH  = 3'd4,
    VERDICT_CHECKSUM      = 3'd5,
    VERDICT_NOT_OURS      = 3'd6
  } verdict_t;

  typedef enum logic [1:0] {
    CLASS_ICMP  = 2'd0,
    CLASS_UDP   = 2'd1,
    CLASS_TCP   = 2'd2,
    CLASS_OTHER = 2'd3
  } protocol_class_t;

  typedef enum logic [1:0] {
    CFG_LOCAL_ADDRESS      = 2'd0,
    CFG_ADDRESS_CONFIGURED = 2'd1,
    CFG_LEASE_NEGOTIATING  = 2'd2
  } cfg_index_t;

  localparam logic [7:0]  PROTO_ICMP        = 8'd1;
  localparam logic [7:0]  PROTO_UDP         = 8'd17;
  localparam logic [7:0]  PROTO_TCP         = 8'd6;
  localparam logic [3:0]  IP_VERSION_4      = 4'd4;
  localparam logic [15:0] MIN_HEADER_BYTES  = 16'd20;
  localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
  localparam logic [31:0] BROADCAST_ADDRESS = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] local_address;
    logic        address_configured;
    logic        lease_negotiating;
  } cfg_t;

  // Everything the verdict stage needs about one finished packet.
  typedef struct packed {
    logic [15:0] byte_count;
    logic [7:0]  version_and_length;
    logic [15:0] dgram_length;
    logic [7:0]  protocol_number;
    logic [31:0] source;
    logic [31:0] destination;
    logic [15:0] stored_checksum;
    logic [15:0] header_sum;
  } pkt_summary_t;

endpackage

>>> rtl/ipv4rhf_front.sv
module ipv4rhf_front import ipv4rhf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output logic         push,
  output pkt_summary_t summary
);

  // Byte offsets of the header fields.
  localparam logic [15:0] OFS_TOTAL_HI = 16'd2;
  localparam logic [15:0] OFS_TOTAL_LO = 16'd3;
  localparam logic [15:0] OFS_PROTOCOL = 16'd9;
  localparam logic [15:0] OFS_CSUM_HI  = 16'd10;
  localparam logic [15:0] OFS_CSUM_LO  = 16'd11;
  localparam logic [15:0] OFS_SRC_FIRST = 16'd12;
  localparam logic [15:0] OFS_SRC_LAST  = 16'd15;
  localparam logic [15:0] OFS_DST_FIRST = 16'd16;
  localparam logic [15:0] OFS_DST_LAST  = 16'd19;

  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  version_and_length, version_and_length_next;
  logic [15:0] total_length_field, total_length_field_next;
  logic [7:0]  protocol_number, protocol_number_next;
  logic [31:0] source_field, source_field_next;
  logic [31:0] destination_field, destination_field_next;
  logic [15:0] stored_checksum, stored_checksum_next;
  logic [15:0] sum_accumulator, sum_accumulator_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;

  logic [5:0]  hlen;
  logic [15:0] word;
  logic [16:0] raw_sum;

  always_comb begin
    version_and_length_next = (byte_count == '0) ? data_byte : version_and_length;
    hlen = {version_and_length_next[3:0], 2'b00};

    total_length_field_next = total_length_field;
    protocol_number_next    = protocol_number;
    stored_checksum_next    = stored_checksum;
    source_field_next       = source_field;
    destination_field_next  = destination_field;
    case (byte_count) inside
      OFS_TOTAL_HI: total_length_field_next = {data_byte, total_length_field[7:0]};
      OFS_TOTAL_LO: total_length_field_next = {total_length_field[15:8], data_byte};
      OFS_PROTOCOL: protocol_number_next = data_byte;
      OFS_CSUM_HI:  stored_checksum_next = {data_byte, stored_checksum[7:0]};
      OFS_CSUM_LO:  stored_checksum_next = {stored_checksum[15:8], data_byte};
      [OFS_SRC_FIRST:OFS_SRC_LAST]: source_field_next = {source_field[23:0], data_byte};
      [OFS_DST_FIRST:OFS_DST_LAST]:
        destination_field_next = {destination_field[23:0], data_byte};
      default: ;
    endcase

    // Ones' complement sum with end-around carry; the checksum word counts as zero.
    word = (byte_count == OFS_CSUM_LO) ? 16'd0 : {high_byte_hold, data_byte};
    raw_sum = {1'b0, sum_accumulator} + {1'b0, word};
    high_byte_hold_next  = high_byte_hold;
    sum_accumulator_next = sum_accumulator;
    if (!byte_count[0]) begin
      high_byte_hold_next = data_byte;
    end else if (byte_count < {10'd0, hlen}) begin
      sum_accumulator_next = raw_sum[15:0] + {15'd0, raw_sum[16]};
    end

    byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      byte_count         <= '0;
      version_and_length <= '0;
      total_length_field <= '0;
      protocol_number    <= '0;
      source_field       <= '0;
      destination_field  <= '0;
      stored_checksum    <= '0;
      sum_accumulator    <= '0;
      high_byte_hold     <= '0;
    end else if (accept) begin
      byte_count         <= byte_count_next;
      version_and_length <= version_and_length_next;
      total_length_field <= total_length_field_next;
      protocol_number    <= protocol_number_next;
      source_field       <= source_field_next;
      destination_field  <= destination_field_next;
      stored_checksum    <= stored_checksum_next;
      sum_accumulator    <= sum_accumulator_next;
      high_byte_hold     <= high_byte_hold_next;
    end
  end

  assign push = accept && last_byte;

  always_comb begin
    summary.byte_count         = byte_count_next;
    summary.version_and_length = version_and_length_next;
    summary.dgram_length       = total_length_field_next;
    summary.protocol_number    = protocol_number_next;
    summary.source             = source_field_next;
    summary.destination        = destination_field_next;
    summary.stored_checksum    = stored_checksum_next;
    summary.header_sum         = sum_accumulator_next;
  end

endmodule

>>> rtl/ipv4rhf_queue.sv
`include "ipv4_receive_header_filter_macros.svh"
module ipv4rhf_queue import ipv4rhf_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  pkt_summary_t push_data,
  input  logic         pop,
  output pkt_summary_t head,
  output logic         empty,
  output logic         full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pkt_summary_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `ASSERT_HOLDS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "queue count above depth")
  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push, !full || pop, "push into a full queue")
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, !empty, "pop from an empty queue")

endmodule

>>> rtl/ipv4rhf_back.sv
`include "ipv4_receive_header_filter_macros.svh"
module ipv4rhf_back import ipv4rhf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  pkt_summary_t head,
  input  logic         empty,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [2:0]   verdict,
  output logic [1:0]   protocol_class,
  output logic [31:0]  source_address,
  output logic [31:0]  destination_address,
  output logic [5:0]   payload_offset,
  output logic [15:0]  payload_length
);

  logic [5:0]      hlen;
  logic [15:0]     hlen_wide;
  logic            ours;
  verdict_t        verdict_next;
  protocol_class_t class_next;
  logic [15:0]     plen_next;
  logic            out_valid_next;

  assign pop = !empty && (!out_valid || !out_stall);

  always_comb begin
    hlen      = {head.version_and_length[3:0], 2'b00};
    hlen_wide = {10'd0, hlen};
    ours = (head.destination == cfg.local_address) ||
           (head.destination == BROADCAST_ADDRESS) ||
           (cfg.local_address == '0 && !cfg.address_configured) ||
           (!cfg.address_configured && cfg.lease_negotiating);

    if (head.byte_count < MIN_HEADER_BYTES) begin
      verdict_next = VERDICT_SHORT;
    end else if (head.version_and_length[7:4] != IP_VERSION_4) begin
      verdict_next = VERDICT_VERSION;
    end else if (hlen_wide < MIN_HEADER_BYTES || hlen_wide > head.byte_count) begin
      verdict_next = VERDICT_HEADER_LENGTH;
    end else if (head.dgram_length > head.byte_count || head.dgram_length < hlen_wide) begin
      verdict_next = VERDICT_TOTAL_LENGTH;
    end else if (~head.header_sum != head.stored_checksum) begin
      verdict_next = VERDICT_CHECKSUM;
    end else if (ours) begin
      verdict_next = VERDICT_ACCEPTED;
    end else begin
      verdict_next = VERDICT_NOT_OURS;
    end

    case (head.protocol_number)
      PROTO_ICMP: class_next = CLASS_ICMP;
      PROTO_UDP:  class_next = CLASS_UDP;
      PROTO_TCP:  class_next = CLASS_TCP;
      default:    class_next = CLASS_OTHER;
    endcase

    plen_next = (verdict_next == VERDICT_ACCEPTED) ? head.dgram_length - hlen_wide : 16'd0;
    out_valid_next = pop || (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict             <= verdict_next;
      protocol_class      <= class_next;
      source_address      <= head.source;
      destination_address <= head.destination;
      payload_offset      <= hlen;
      payload_length      <= plen_next;
    end
  end

  `ASSERT_IMPLIES(a_reject_zero_len, clk, rst, out_valid && verdict != VERDICT_ACCEPTED, payload_length == 16'd0, "rejected packet carries a payload length")
  `ASSERT_IMPLIES(a_accept_hlen, clk, rst, out_valid && verdict == VERDICT_ACCEPTED, payload_offset >= 6'd20, "accepted packet with a short header")
  `ASSERT_HOLDS(a_verdict_range, clk, rst, !out_valid || verdict <= VERDICT_NOT_OURS, "verdict code out of range")

endmodule

>>> rtl/ipv4_receive_header_filter.sv
// Channel   Direction  Handshake              Payload
// in        receive    in_valid / in_stall    data_byte, last_byte
// out       send       out_valid / out_stall  verdict, protocol_class, source_address,
//                                             destination_address, payload_offset,
//                                             payload_length
// cfg       receive    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle unless the input is stalled. A packet's summary enters the
// queue when its last byte is accepted; the verdict stage registers its result when it
// pops that summary. The front stalls the input only while the summary queue is full,
// which with the default depth means two finished packets wait behind a stalled output.
// Reset is synchronous and clears the configuration, the queue and all per-packet state.
module ipv4_receive_header_filter import ipv4rhf_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // Byte stream in.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // One result per packet out.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  verdict,
  output logic [1:0]  protocol_class,
  output logic [31:0] source_address,
  output logic [31:0] destination_address,
  output logic [5:0]  payload_offset,
  output logic [15:0] payload_length,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t         cfg;
  logic         in_accept;
  logic         push;
  logic         pop;
  logic         q_empty;
  logic         q_full;
  pkt_summary_t push_data;
  pkt_summary_t q_head;

  // Configuration writes are always taken; an index past the register list is ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOCAL_ADDRESS:      cfg.local_address      <= cfg_data;
        CFG_ADDRESS_CONFIGURED: cfg.address_configured <= cfg_data[0];
        CFG_LEASE_NEGOTIATING:  cfg.lease_negotiating  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The front only holds the stream back when it has nowhere to put a finished packet.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  // Front: captures header fields and keeps the running header checksum per byte.
  ipv4rhf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .push      (push),
    .summary   (push_data)
  );

  // Short queue of finished packet summaries that decouples the two sides.
  ipv4rhf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Back: runs the checks in order and holds the result until the consumer takes it.
  ipv4rhf_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .cfg                 (cfg),
    .head                (q_head),
    .empty               (q_empty),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .verdict             (verdict),
    .protocol_class      (protocol_class),
    .source_address      (source_address),
    .destination_address (destination_address),
    .payload_offset      (payload_offset),
    .payload_length      (payload_length)
  );

endmodule
